@@ rtl/core/mexp_pkg.sv @@
// shared widths, reset value and types for the modular exponentiation block
package mexp_pkg;

   // operand and exponent widths
   localparam int ModWidth   = 31;
   localparam int ExpWidth   = 32;

   // serial multiplier step count and round count widths
   localparam int StepWidth  = $clog2(ModWidth);
   localparam int RoundWidth = $clog2(ExpWidth + 1);

   // modulus after reset
   localparam logic [ModWidth-1:0] ModulusReset = ModWidth'(998244353);

   typedef logic [ModWidth-1:0] residue_type;
   typedef logic [ExpWidth-1:0] exponent_type;

endpackage

@@ rtl/core/mexp_mul.sv @@
// bit-serial interleaved modular multiplier, one bit per step cycle
module mexp_mul (
   input  logic                clock,
   input  logic                load,
   input  logic                step,
   input  mexp_pkg::residue_type op_a,
   input  mexp_pkg::residue_type op_b,
   input  mexp_pkg::residue_type modulus,
   output mexp_pkg::residue_type product
);
   import mexp_pkg::*;

   residue_type           a_ff;
   residue_type           b_ff;
   residue_type           r_ff;
   residue_type           r_in;
   logic [ModWidth+1:0]   sum;
   logic [ModWidth+1:0]   mod_x1;
   logic [ModWidth+1:0]   mod_x2;
   logic [ModWidth+1:0]   diff_x1;
   logic [ModWidth+1:0]   diff_x2;

   // shift in the next multiplier bit and fold back below the modulus
   always_comb begin
      mod_x1  = {2'b00, modulus};
      mod_x2  = {1'b0, modulus, 1'b0};
      sum     = {1'b0, r_ff, 1'b0} + (a_ff[ModWidth-1] ? {2'b00, b_ff} : '0);
      diff_x1 = sum - mod_x1;
      diff_x2 = sum - mod_x2;
      if (sum >= mod_x2) begin
         r_in = diff_x2[ModWidth-1:0];
      end else if (sum >= mod_x1) begin
         r_in = diff_x1[ModWidth-1:0];
      end else begin
         r_in = sum[ModWidth-1:0];
      end
   end

   // operand shift register and partial result
   always_ff @(posedge clock) begin
      if (load) begin
         a_ff <= op_a;
         b_ff <= op_b;
         r_ff <= '0;
      end else if (step) begin
         a_ff <= {a_ff[ModWidth-2:0], 1'b0};
         r_ff <= r_in;
      end
   end

   assign product = r_ff;

endmodule

@@ rtl/core/modular_exponentiation.sv @@
// modular exponentiation top level: right-to-left square-and-multiply
//
// Usage: a transfer on the req_ channel carries req_base_value and
// req_exponent; one transfer on the rsp_ channel later returns
// rsp_power_result = base ** exponent mod the configured modulus.
// The modulus is written through csr_wr_en / csr_wr_data; the user must write
// it only while the block is idle, which the block itself does not enforce.
// It resets to 998244353. A modulus of 0 or 1 gives a result of 0.
// The work runs in 33 rounds (one base reduction, then one round per exponent
// bit); each round is one load, 31 steps of the two bit-serial multipliers
// (31 modulus bits, one bit per cycle), then one update. Moduli below 2 skip
// the rounds: the block goes straight from the request to writing the result.
// One item is worked on at a time; req_stall is high while it runs.
// The result waits in an output register: if rsp_stall holds it, the next
// item is still taken and computed, and its result waits until the output
// register is free.
// Reset (synchronous, active high) returns to idle, drops rsp_valid and
// restores the default modulus.
module modular_exponentiation (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  mexp_pkg::residue_type  csr_wr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mexp_pkg::residue_type  req_base_value,
   input  mexp_pkg::exponent_type req_exponent,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mexp_pkg::residue_type  rsp_power_result
);
   import mexp_pkg::*;

   // sequencer states
   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StLoad   = 3'd1;
   localparam logic [2:0] StRun    = 3'd2;
   localparam logic [2:0] StUpdate = 3'd3;
   localparam logic [2:0] StWrite  = 3'd4;

   localparam logic [StepWidth-1:0]  LastStep  = StepWidth'(ModWidth - 1);
   localparam logic [RoundWidth-1:0] LastRound = RoundWidth'(ExpWidth);

   logic [2:0]            state_ff;
   logic [2:0]            state_in;
   residue_type           modulus_ff;
   residue_type           acc_ff;
   residue_type           sq_ff;
   exponent_type          exp_ff;
   logic [StepWidth-1:0]  step_ff;
   logic [RoundWidth-1:0] round_ff;
   logic                  rsp_valid_ff;
   residue_type           rsp_result_ff;
   logic                  req_take;
   logic                  out_free;
   logic                  mul_load;
   logic                  mul_step;
   logic                  small_mod;
   logic                  take_mul;
   residue_type           sq_op_b;
   residue_type           acc_prod;
   residue_type           sq_prod;

   assign req_take  = req_valid && (state_ff == StIdle);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign mul_load  = (state_ff == StLoad);
   assign mul_step  = (state_ff == StRun);
   assign small_mod = (modulus_ff[ModWidth-1:1] == '0);
   // round zero reduces the base by multiplying by one
   assign sq_op_b   = (round_ff == '0) ? ModWidth'(1) : sq_ff;
   assign take_mul  = (round_ff != '0) && exp_ff[0];

   // accumulator times square
   mexp_mul u_mul_acc (
      .clock   (clock),
      .load    (mul_load),
      .step    (mul_step),
      .op_a    (acc_ff),
      .op_b    (sq_ff),
      .modulus (modulus_ff),
      .product (acc_prod)
   );

   // square times square, or times one in round zero
   mexp_mul u_mul_sq (
      .clock   (clock),
      .load    (mul_load),
      .step    (mul_step),
      .op_a    (sq_ff),
      .op_b    (sq_op_b),
      .modulus (modulus_ff),
      .product (sq_prod)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         StIdle: begin
            if (req_take) begin
               state_in = small_mod ? StWrite : StLoad;
            end
         end
         StLoad: begin
            state_in = StRun;
         end
         StRun: begin
            if (step_ff == '0) begin
               state_in = StUpdate;
            end
         end
         StUpdate: begin
            state_in = (round_ff == LastRound) ? StWrite : StLoad;
         end
         StWrite: begin
            if (out_free) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         modulus_ff   <= ModulusReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            modulus_ff <= csr_wr_data;
         end
         if (state_ff == StWrite && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         StIdle: begin
            if (req_take) begin
               acc_ff   <= small_mod ? '0 : ModWidth'(1);
               sq_ff    <= req_base_value;
               exp_ff   <= req_exponent;
               round_ff <= '0;
            end
         end
         StLoad: begin
            step_ff <= LastStep;
         end
         StRun: begin
            step_ff <= step_ff - StepWidth'(1);
         end
         StUpdate: begin
            sq_ff    <= sq_prod;
            round_ff <= round_ff + RoundWidth'(1);
            if (take_mul) begin
               acc_ff <= acc_prod;
            end
            if (round_ff != '0) begin
               exp_ff <= {1'b0, exp_ff[ExpWidth-1:1]};
            end
         end
         StWrite: begin
            if (out_free) begin
               rsp_result_ff <= acc_ff;
            end
         end
         default: begin
            step_ff <= step_ff;
         end
      endcase
   end

   assign req_stall        = (state_ff != StIdle);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_result_ff;

endmodule
